>>> rtl/chca_pkg.sv
// ----------------------------------------------------------------------------
// chca_pkg : shared types and constants
// Sizes, command codes, controller states and the control bundle that the
// sequencer drives into the code table.
// ----------------------------------------------------------------------------
package chca_pkg;

    localparam int NUM_SYMBOLS  = 288;
    localparam int MAX_CODE_LEN = 15;

    // input and output field widths
    localparam int CMD_W  = 2;
    localparam int SYM_W  = 9;
    localparam int LEN_W  = 4;
    localparam int CODE_W = 15;

    localparam int NUM_LENS = MAX_CODE_LEN + 1;
    localparam int ADDR_W   = $clog2(NUM_SYMBOLS);
    localparam int HIST_W   = $clog2(NUM_SYMBOLS + 1);
    localparam int NEXT_W   = 16;
    // first-code accumulator never wraps: bounded by NUM_SYMBOLS * 2^(MAX+1)
    localparam int ACC_W    = HIST_W + MAX_CODE_LEN + 2;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CODE_W-1:0] t_code;

    localparam t_addr LAST_ADDR = ADDR_W'(NUM_SYMBOLS - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_BUILD = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_LOAD,
        S_QUERY,
        S_FIRST,
        S_WALK,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic clr;          // zero the histogram
        logic load;         // move one symbol from old_len to new_len
        t_len old_len;
        t_len new_len;
        logic first_init;   // restart first-code pass
        logic first_step;   // one length of the first-code pass
        t_len bits;
        logic walk;         // hand out next code of walk_len
        t_len walk_len;
    } t_tab_ctrl;

endpackage

>>> rtl/chca_ram.sv
// ----------------------------------------------------------------------------
// chca_ram : simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module chca_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 288
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/chca_code_table.sv
// ----------------------------------------------------------------------------
// chca_code_table : length histogram and next-code table
// Keeps the count of used symbols per length, derives the first code of each
// length one length per cycle, and hands out consecutive codes in the walk.
// ----------------------------------------------------------------------------
module chca_code_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  chca_pkg::t_tab_ctrl  i_ctrl,
    output chca_pkg::t_code      o_code,
    output logic                 o_over
);
    import chca_pkg::*;

    logic [HIST_W-1:0] r_hist [NUM_LENS];
    logic [NEXT_W-1:0] r_next [NUM_LENS];
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    logic [HIST_W-1:0] r_prev;
    logic              r_over;
    logic              w_over_hit;
    logic [HIST_W-1:0] w_hist_b;
    logic [NUM_LENS-1:0] w_dec;
    logic [NUM_LENS-1:0] w_inc;

    assign w_hist_b   = r_hist[i_ctrl.bits];
    assign n_acc      = (r_acc + ACC_W'(r_prev)) << 1;
    // codes of this length must fit below 2^bits
    assign w_over_hit = (n_acc + ACC_W'(w_hist_b)) > (ACC_W'(1) << i_ctrl.bits);

    always_comb begin
        for (int i = 0; i < NUM_LENS; i++) begin
            w_dec[i] = (i_ctrl.old_len == LEN_W'(i)) && (i_ctrl.old_len != '0)
                       && (r_hist[i] != '0);
            w_inc[i] = (i_ctrl.new_len == LEN_W'(i)) && (i_ctrl.new_len != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LENS; i++) begin
                r_hist[i] <= '0;
                r_next[i] <= '0;
            end
            r_acc  <= '0;
            r_prev <= '0;
            r_over <= 1'b0;
        end else begin
            if (i_ctrl.clr) begin
                for (int i = 0; i < NUM_LENS; i++) begin
                    r_hist[i] <= '0;
                end
            end else if (i_ctrl.load) begin
                for (int i = 0; i < NUM_LENS; i++) begin
                    r_hist[i] <= r_hist[i] - HIST_W'(w_dec[i]) + HIST_W'(w_inc[i]);
                end
            end

            if (i_ctrl.first_init) begin
                r_acc  <= '0;
                r_prev <= '0;
                r_over <= 1'b0;
            end else if (i_ctrl.first_step) begin
                r_acc  <= n_acc;
                r_prev <= w_hist_b;
                r_over <= r_over | w_over_hit;
                r_next[i_ctrl.bits] <= n_acc[NEXT_W-1:0];
            end

            if (i_ctrl.walk && (i_ctrl.walk_len != '0)) begin
                r_next[i_ctrl.walk_len] <= r_next[i_ctrl.walk_len] + NEXT_W'(1);
            end
        end
    end

    always_comb begin
        if (i_ctrl.walk_len != '0) begin
            o_code = r_next[i_ctrl.walk_len][CODE_W-1:0];
        end else begin
            o_code = '0;
        end
    end

    assign o_over = r_over;

endmodule

>>> rtl/canonical_huffman_code_assigner_unit.sv
// ----------------------------------------------------------------------------
// canonical_huffman_code_assigner_unit : canonical prefix code assignment
// Stores per-symbol code lengths, builds canonical codes from the length
// histogram and answers per-symbol code queries.
//
//   channel  dir  transaction carries
//   s_axis   in   command, symbol, length
//   m_axis   out  code, code_bits, table_built, oversubscribed (one per input)
//
// Load and query read the length RAM, then update or reply. Clear runs a
// sweep that zeroes the length RAM, one entry a cycle. Build runs the
// first-code pass, then a walk of the length RAM feeding the code RAM.
// After reset the same sweep runs with s_axis not ready.
// A new transaction is taken while a result is being handed over.
// ----------------------------------------------------------------------------
module canonical_huffman_code_assigner_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // [1:0] command, [10:2] symbol, [14:11] length, [15] zero
    input  logic [chca_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [14:0] code, [18:15] code_bits, [19] table_built,
    // [20] oversubscribed, [23:21] zero
    output logic [chca_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready
);
    import chca_pkg::*;

    t_state r_state, n_state;

    t_cmd              w_cmd;
    logic [SYM_W-1:0]  w_sym;
    t_len              w_len;
    logic              w_fire;
    logic              w_sym_ok;
    logic              w_len_ok;

    // sequencing registers
    t_addr  r_sym,  n_sym;
    t_len   r_bits, n_bits;
    logic   r_wpend, n_wpend;
    t_addr  r_waddr;
    logic   r_clr_reply, n_clr_reply;
    logic   r_built, n_built;
    logic   r_over, n_over;
    logic   r_in_ok;
    t_len   r_in_len;

    // result register
    logic   r_out_valid;
    t_code  r_out_code;
    t_len   r_out_bits;
    logic   r_out_built;
    logic   r_out_over;
    logic   w_out_load;
    t_code  w_out_code;
    t_len   w_out_bits;

    // memory ports
    logic   w_len_we,  w_len_re;
    t_addr  w_len_waddr, w_len_raddr;
    t_len   w_len_wdata, w_len_rdata;
    logic   w_code_we, w_code_re;
    t_addr  w_code_raddr;
    t_code  w_code_rdata;

    t_tab_ctrl w_tab;
    t_code     w_tab_code;
    logic      w_tab_over;

    assign w_cmd    = t_cmd'(i_s_tdata[1:0]);
    assign w_sym    = i_s_tdata[10:2];
    assign w_len    = i_s_tdata[14:11];
    assign w_sym_ok = ({1'b0, w_sym} < (SYM_W + 1)'(NUM_SYMBOLS));
    assign w_len_ok = (32'(w_len) <= MAX_CODE_LEN);

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_fire     = i_s_tvalid && o_s_tready;

    chca_ram #(
        .WIDTH (LEN_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (w_len_we),
        .i_waddr (w_len_waddr),
        .i_wdata (w_len_wdata),
        .i_re    (w_len_re),
        .i_raddr (w_len_raddr),
        .o_rdata (w_len_rdata)
    );

    chca_ram #(
        .WIDTH (CODE_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (w_code_we),
        .i_waddr (r_waddr),
        .i_wdata (w_tab_code),
        .i_re    (w_code_re),
        .i_raddr (w_code_raddr),
        .o_rdata (w_code_rdata)
    );

    chca_code_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_tab),
        .o_code  (w_tab_code),
        .o_over  (w_tab_over)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_SWEEP: begin
                if (r_sym == LAST_ADDR) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_fire) begin
                    unique case (w_cmd)
                        CMD_CLEAR: n_state = S_SWEEP;
                        CMD_LOAD:  n_state = S_LOAD;
                        CMD_BUILD: n_state = S_FIRST;
                        CMD_QUERY: n_state = S_QUERY;
                    endcase
                end
            end
            S_LOAD:  n_state = S_IDLE;
            S_QUERY: n_state = S_IDLE;
            S_FIRST: begin
                if (r_bits == LEN_W'(MAX_CODE_LEN)) n_state = S_WALK;
            end
            S_WALK: begin
                if (r_sym == LAST_ADDR) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        w_len_we     = 1'b0;
        w_len_waddr  = r_sym;
        w_len_wdata  = '0;
        w_len_re     = 1'b0;
        w_len_raddr  = r_sym;
        w_code_re    = 1'b0;
        w_code_raddr = w_sym[ADDR_W-1:0];
        w_tab        = '0;
        w_out_load   = 1'b0;
        w_out_code   = '0;
        w_out_bits   = '0;
        n_sym        = r_sym;
        n_bits       = r_bits;
        n_wpend      = 1'b0;
        n_clr_reply  = r_clr_reply;
        n_built      = r_built;
        n_over       = r_over;

        // code RAM write side of the walk, in the cycle after the length read
        w_code_we     = r_wpend;
        w_tab.walk     = r_wpend;
        w_tab.walk_len = w_len_rdata;

        unique case (r_state)
            S_SWEEP: begin
                w_len_we = 1'b1;
                n_sym    = r_sym + ADDR_W'(1);
                if (r_sym == LAST_ADDR) begin
                    w_out_load  = r_clr_reply;
                    n_clr_reply = 1'b0;
                end
            end
            S_IDLE: begin
                if (w_fire) begin
                    unique case (w_cmd)
                        CMD_CLEAR: begin
                            w_tab.clr   = 1'b1;
                            n_sym       = '0;
                            n_clr_reply = 1'b1;
                            n_built     = 1'b0;
                            n_over      = 1'b0;
                        end
                        CMD_LOAD: begin
                            w_len_re    = w_sym_ok;
                            w_len_raddr = w_sym[ADDR_W-1:0];
                        end
                        CMD_BUILD: begin
                            w_tab.first_init = 1'b1;
                            n_bits           = LEN_W'(1);
                        end
                        CMD_QUERY: begin
                            w_len_re    = w_sym_ok;
                            w_len_raddr = w_sym[ADDR_W-1:0];
                            w_code_re   = w_sym_ok;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                if (r_in_ok) begin
                    w_tab.load    = 1'b1;
                    w_tab.old_len = w_len_rdata;
                    w_tab.new_len = r_in_len;
                    w_len_we      = 1'b1;
                    w_len_waddr   = r_waddr;
                    w_len_wdata   = r_in_len;
                    n_built       = 1'b0;
                    n_over        = 1'b0;
                end
                w_out_load = 1'b1;
            end
            S_QUERY: begin
                if (r_in_ok) begin
                    w_out_bits = w_len_rdata;
                    if (r_built && (w_len_rdata != '0)) w_out_code = w_code_rdata;
                end
                w_out_load = 1'b1;
            end
            S_FIRST: begin
                w_tab.first_step = 1'b1;
                w_tab.bits       = r_bits;
                n_bits           = r_bits + LEN_W'(1);
                n_sym            = '0;
            end
            S_WALK: begin
                w_len_re = 1'b1;
                n_wpend  = 1'b1;
                n_sym    = r_sym + ADDR_W'(1);
            end
            S_DRAIN: begin
                n_built    = 1'b1;
                n_over     = w_tab_over;
                w_out_load = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sym       <= '0;
            r_bits      <= '0;
            r_wpend     <= 1'b0;
            r_clr_reply <= 1'b0;
            r_built     <= 1'b0;
            r_over      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sym       <= n_sym;
            r_bits      <= n_bits;
            r_wpend     <= n_wpend;
            r_clr_reply <= n_clr_reply;
            r_built     <= n_built;
            r_over      <= n_over;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_in_ok  <= (w_cmd == CMD_LOAD) ? (w_sym_ok && w_len_ok) : w_sym_ok;
            r_in_len <= w_len;
            r_waddr  <= w_sym[ADDR_W-1:0];
        end else if (r_state == S_WALK) begin
            r_waddr  <= r_sym;
        end
        if (w_out_load) begin
            r_out_code  <= w_out_code;
            r_out_bits  <= w_out_bits;
            r_out_built <= n_built;
            r_out_over  <= n_over;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_over, r_out_built, r_out_bits, r_out_code};

    // ---------------------------------------------------------------- checks
    a_query_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_cmd == CMD_QUERY)) |=> (r_state == S_QUERY))
        else $error("query did not move to reply state");

    a_no_accept_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("accept while result register is held");

    a_wpend_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpend |-> ($past(r_state) == S_WALK))
        else $error("code write outside the walk");

    a_build_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> (r_built && r_out_valid && r_out_built))
        else $error("build finished without built flag and result");

    a_result_not_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) != S_IDLE))
        else $error("result without a command in progress");

endmodule
